// ----- sv/cbrk_pkg.sv -----
// Package for the multi-bus circuit breaker: sizes, action and register codes,
// beat payload structs, per-bus entry type and sequencer states.
// No dependencies.
`default_nettype none

package cbrk_pkg;

  localparam int NUM_BUSES = 8;
  localparam int IDX_W     = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int BUS_W     = 3;
  localparam int ACT_W     = 3;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_SUCCESS = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FAILURE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RESET   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_HOLD_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECTION_ON = 3'd4;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [BUS_W-1:0] bus;
  } in_item_t;

  typedef struct packed {
    logic [BUS_W-1:0] bus_out;
    logic [1:0]       breaker_mode;
    logic             available;
    logic [CNT_W-1:0] failures;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  failure_limit;
    logic [CNT_W-1:0]  success_limit;
    logic [TIME_W-1:0] open_hold_ms;
    logic [TIME_W-1:0] decay_ms;
    logic              protection_on;
  } cfg_regs_t;

  typedef struct packed {
    mode_t             mode;
    logic [CNT_W-1:0]  fail;
    logic [CNT_W-1:0]  succ;
    logic [TIME_W-1:0] opened;
    logic [TIME_W-1:0] last_fail;
  } bus_entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- sv/multi_bus_circuit_breaker_core.sv -----
// Multi-bus circuit breaker, top level.
// Sequencing: an event beat (success, failure, reset, query) passes through the execute
// and report states; a tick beat sweeps every bus in the tick state, the sequencer walking
// one bus per cycle through the shared elapsed-time comparator, and then reports.
// A new beat is taken only once the previous one has been reported, and the report waits
// while the output register is held by out_stall. Synchronous reset clears all breakers.
`default_nettype none

// The block keeps one closed/open/half-open breaker per bus and a millisecond
// clock advanced by tick beats. Input is accepted only while the sequencer is
// idle; the result sits in an output register, so a new beat can be taken while
// the previous result still waits downstream. Configuration writes are plain
// register writes and take effect on the next clock.
module multi_bus_circuit_breaker_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration port.
  input  wire logic                           cfg_we,
  input  wire logic [cbrk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cbrk_pkg::CFG_DW-1:0]    cfg_wdata,
  // Input channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire cbrk_pkg::in_item_t             in_data,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output cbrk_pkg::out_item_t                 out_data
);
  import cbrk_pkg::*;

  cfg_regs_t regs;

  // Thresholds, hold and decay times, and the protection bypass.
  cbrk_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // The sequencer owns the breaker table and the millisecond clock. An event
  // reads, updates and writes back one entry; a tick sweeps every entry, one per
  // cycle, then reports the addressed bus like any other beat.
  cbrk_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- sv/cbrk_cfg.sv -----
// Configuration register bank of the circuit breaker.
// Depends on cbrk_pkg for register codes and the cfg_regs_t struct.
`default_nettype none

module cbrk_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cbrk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cbrk_pkg::CFG_DW-1:0]    cfg_wdata,
  output cbrk_pkg::cfg_regs_t                 regs
);
  import cbrk_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FAILURE_LIMIT: begin
          // A zero limit is ignored.
          if (cfg_wdata[CNT_W-1:0] != '0) regs_nxt.failure_limit = cfg_wdata[CNT_W-1:0];
        end
        REG_SUCCESS_LIMIT: regs_nxt.success_limit = cfg_wdata[CNT_W-1:0];
        REG_OPEN_HOLD_MS: begin
          if (cfg_wdata[TIME_W-1:0] != '0) regs_nxt.open_hold_ms = cfg_wdata[TIME_W-1:0];
        end
        REG_DECAY_MS:      regs_nxt.decay_ms = cfg_wdata[TIME_W-1:0];
        REG_PROTECTION_ON: regs_nxt.protection_on = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.failure_limit <= CNT_W'(5);
      regs_r.success_limit <= CNT_W'(3);
      regs_r.open_hold_ms  <= TIME_W'(5000);
      regs_r.decay_ms      <= TIME_W'(60000);
      regs_r.protection_on <= 1'b1;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ----- sv/cbrk_cmp.sv -----
// Shared elapsed/threshold unit: (a - b) modulo 2^32 compared against a limit.
// Depends on cbrk_pkg for widths.
`default_nettype none

module cbrk_cmp (
  input  wire logic [cbrk_pkg::TIME_W-1:0] a,
  input  wire logic [cbrk_pkg::TIME_W-1:0] b,
  input  wire logic [cbrk_pkg::TIME_W-1:0] limit,
  output logic                             reached
);
  import cbrk_pkg::*;

  logic [TIME_W-1:0] diff;

  assign diff    = a - b;
  assign reached = (diff >= limit);

endmodule

`default_nettype wire

// ----- sv/cbrk_engine.sv -----
// Sequencer and per-bus breaker state. Runs one step per event and one bus
// per cycle on a tick, all through the shared cbrk_cmp unit.
// Depends on cbrk_pkg and cbrk_cmp.
`default_nettype none

module cbrk_engine (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbrk_pkg::cfg_regs_t  regs,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cbrk_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cbrk_pkg::out_item_t       out_data
);
  import cbrk_pkg::*;

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [BUS_W-1:0]  bus_r, bus_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  bus_entry_t        entry_r [NUM_BUSES];
  bus_entry_t        cur;
  bus_entry_t        ent_nxt;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  bus_idx;
  logic              bus_ok;
  logic [CNT_W-1:0]  inc_fail;
  logic [CNT_W-1:0]  inc_succ;

  logic [TIME_W-1:0] cmp_a, cmp_b, cmp_lim;
  logic              cmp_ge;

  cbrk_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .limit   (cmp_lim),
    .reached (cmp_ge)
  );

  assign bus_ok   = (TIME_W'(bus_r) < TIME_W'(NUM_BUSES));
  assign bus_idx  = IDX_W'(bus_r);
  assign rd_idx   = (state_r == ST_TICK) ? idx_r : bus_idx;
  assign cur      = entry_r[rd_idx];
  assign inc_fail = sat_inc(cur.fail);
  assign inc_succ = sat_inc(cur.succ);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    bus_nxt       = bus_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    ent_nxt       = cur;
    cmp_a         = '0;
    cmp_b         = '0;
    cmp_lim       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt = in_data.action;
          bus_nxt = in_data.bus;
          if (in_data.action == ACT_TICK) begin
            now_nxt   = now_r + 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        state_nxt = ST_REPORT;
        if (bus_ok) begin
          case (act_r)
            ACT_SUCCESS: begin
              cmp_a        = TIME_W'(inc_succ);
              cmp_lim      = TIME_W'(regs.success_limit);
              wr_en        = 1'b1;
              ent_nxt.succ = inc_succ;
              ent_nxt.fail = '0;
              if (cur.mode == MODE_HALF && cmp_ge) begin
                ent_nxt.mode = MODE_CLOSED;
                ent_nxt.succ = '0;
              end
            end
            ACT_FAILURE: begin
              cmp_a             = TIME_W'(inc_fail);
              cmp_lim           = TIME_W'(regs.failure_limit);
              wr_en             = 1'b1;
              ent_nxt.fail      = inc_fail;
              ent_nxt.last_fail = now_r;
              if ((cur.mode == MODE_CLOSED && cmp_ge) || cur.mode == MODE_HALF) begin
                ent_nxt.mode   = MODE_OPEN;
                ent_nxt.opened = now_r;
              end
            end
            ACT_RESET: begin
              wr_en          = 1'b1;
              ent_nxt.mode   = MODE_CLOSED;
              ent_nxt.fail   = '0;
              ent_nxt.succ   = '0;
              ent_nxt.opened = '0;
            end
            default: ;
          endcase
        end
      end

      ST_TICK: begin
        cmp_a = now_r;
        if (cur.mode == MODE_OPEN) begin
          cmp_b   = cur.opened;
          cmp_lim = regs.open_hold_ms;
          if (cmp_ge) begin
            wr_en        = 1'b1;
            ent_nxt.mode = MODE_HALF;
            ent_nxt.succ = '0;
          end
        end else begin
          cmp_b   = cur.last_fail;
          cmp_lim = regs.decay_ms;
          if (cur.mode == MODE_CLOSED && cur.fail != '0 && cmp_ge) begin
            wr_en        = 1'b1;
            ent_nxt.fail = '0;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(NUM_BUSES - 1)) begin
          state_nxt = ST_REPORT;
        end
      end

      ST_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_nxt.bus_out = bus_r;
          if (bus_ok) begin
            out_nxt.breaker_mode = cur.mode;
            out_nxt.available    = !regs.protection_on || cur.mode != MODE_OPEN;
            out_nxt.failures     = cur.fail;
          end else begin
            out_nxt.breaker_mode = MODE_OPEN;
            out_nxt.available    = 1'b0;
            out_nxt.failures     = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    bus_r <= bus_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUSES; i++) begin
        entry_r[i] <= '{mode: MODE_CLOSED, fail: '0, succ: '0, opened: '0, last_fail: '0};
      end
    end else if (wr_en) begin
      entry_r[rd_idx] <= ent_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- sv/cbrk_checker.sv -----
// Port-level checker for the circuit breaker, bound to the top level.
// Depends on cbrk_pkg for the payload structs and mode codes.
`default_nettype none

module cbrk_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire cbrk_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire cbrk_pkg::out_item_t out_data
);
  import cbrk_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only an open breaker may report unavailable.
  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.available |-> out_data.breaker_mode == MODE_OPEN)
    else $error("unavailable result with non-open mode");

  // The sequencer is busy right after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // A new result only appears after the sequencer has been busy.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // A stalled input beat stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

endmodule

bind multi_bus_circuit_breaker_core cbrk_checker u_cbrk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
